@@ src/pressure_temperature_compensation_unit_macros.svh @@
// Assertion macros for the pressure/temperature compensation unit.
// Both expect clk and rst_n in the scope where they are used.
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_UNIT_MACROS_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_UNIT_MACROS_SVH

// Same-cycle implication.
`define PTC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PTC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/ptc_pkg.sv @@
// ----------------------------------------------------------------------------
// ptc_pkg
// Constants and types for the pressure/temperature compensation unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ptc_pkg;

  typedef enum logic [1:0] {
    REG_TEMP_COEFFS  = 2'd0,
    REG_PRESS_LOW    = 2'd1,
    REG_PRESS_HIGH   = 2'd2,
    REG_PRESS_LAST   = 2'd3
  } reg_idx_t;

  localparam int PADDR_W   = 5;
  localparam int TEMP_MIN  = -4000;
  localparam int TEMP_MAX  = 8500;
  localparam int PRESS_MAX = 28160000;

  // divider geometry
  localparam int UD_W      = 40;   // divisor magnitude
  localparam int NUM_W     = 76;   // |numerator| * 3125
  localparam int DIV_STEPS = 37;   // quotient bits
  localparam logic [DIV_STEPS-1:0] QUOT_LIMIT = DIV_STEPS'(64'd68719476736);

  // 15 front stages, one per quotient bit, 5 back stages
  localparam int LATENCY   = 15 + DIV_STEPS + 5;
  localparam int TEMP_TAPS = LATENCY - 4;
  localparam int PNUM_TAPS = 8;

endpackage

`default_nettype wire

@@ src/pressure_temperature_compensation_unit.sv @@
// ----------------------------------------------------------------------------
// pressure_temperature_compensation_unit
// Barometric sensor temperature and pressure compensation, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Input: an item (raw pressure, raw temperature) is taken at each clock edge
//   with start high and busy low. busy is always low: one item per cycle.
//   Output: out_valid strobes for one cycle with temperature (0.01 degC),
//   pressure (Pa, Q17.8) and divide_error. Results leave in input order.
//   Every item passes through 15 front stages (temperature polynomial,
//   pressure polynomial, divisor and numerator scaling), 37 stages of the
//   restoring divider (one quotient bit per stage) and 5 back stages
//   (second-order correction and saturation). Throughput is 1 item per
//   cycle.
//   The receiver cannot stall; results are shown once and never held.
//   Configuration: APB-style, 64-bit data, register i at byte address 8*i,
//   pready always high. Coefficients may change only while no item is in
//   flight.
//   Reset (rst_n low, synchronous) clears coefficients and drops all items in
//   flight.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pressure_temperature_compensation_unit_macros.svh"

module pressure_temperature_compensation_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [19:0]                  in_raw_pressure,
  input  logic [19:0]                  in_raw_temperature,
  output logic                         out_valid,
  output logic signed [14:0]           out_temperature_centi,
  output logic [24:0]                  out_pressure_q8,
  output logic                         out_divide_error,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ptc_pkg::PADDR_W-1:0]  paddr,
  input  logic [63:0]                  pwdata,
  output logic [63:0]                  prdata,
  output logic                         pready
);

  localparam int UD_W  = ptc_pkg::UD_W;
  localparam int NUM_W = ptc_pkg::NUM_W;
  localparam int QW    = ptc_pkg::DIV_STEPS;
  localparam int LAT   = ptc_pkg::LATENCY;

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------
  logic [47:0] temp_coeffs_r;
  logic [63:0] press_low_r;
  logic [63:0] press_high_r;
  logic [15:0] press_last_r;
  logic [LAT-1:0] vld_r;
  logic        cfg_wr;
  ptc_pkg::reg_idx_t cfg_idx;

  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = ptc_pkg::reg_idx_t'(paddr[4:3]);
  assign pready  = 1'b1;
  assign busy    = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_coeffs_r <= '0;
      press_low_r   <= '0;
      press_high_r  <= '0;
      press_last_r  <= '0;
      vld_r         <= '0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_idx)
          ptc_pkg::REG_TEMP_COEFFS: temp_coeffs_r <= pwdata[47:0];
          ptc_pkg::REG_PRESS_LOW:   press_low_r   <= pwdata;
          ptc_pkg::REG_PRESS_HIGH:  press_high_r  <= pwdata;
          ptc_pkg::REG_PRESS_LAST:  press_last_r  <= pwdata[15:0];
        endcase
      end
      vld_r <= {vld_r[LAT-2:0], start && !busy};
    end
  end

  always_comb begin
    unique case (cfg_idx)
      ptc_pkg::REG_TEMP_COEFFS: prdata = {16'h0, temp_coeffs_r};
      ptc_pkg::REG_PRESS_LOW:   prdata = press_low_r;
      ptc_pkg::REG_PRESS_HIGH:  prdata = press_high_r;
      ptc_pkg::REG_PRESS_LAST:  prdata = {48'h0, press_last_r};
    endcase
  end

  logic [15:0]        t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

  assign t1 = temp_coeffs_r[15:0];
  assign t2 = $signed(temp_coeffs_r[31:16]);
  assign t3 = $signed(temp_coeffs_r[47:32]);
  assign p1 = press_low_r[15:0];
  assign p2 = $signed(press_low_r[31:16]);
  assign p3 = $signed(press_low_r[47:32]);
  assign p4 = $signed(press_low_r[63:48]);
  assign p5 = $signed(press_high_r[15:0]);
  assign p6 = $signed(press_high_r[31:16]);
  assign p7 = $signed(press_high_r[47:32]);
  assign p8 = $signed(press_high_r[63:48]);
  assign p9 = $signed(press_last_r);

  // --------------------------------------------------------------------------
  // front stages 1..15
  // --------------------------------------------------------------------------
  logic signed [17:0] t1d_r, t1d_nxt;
  logic signed [16:0] dt_r, dt_nxt;
  logic [20:0]        pnum_nxt;
  logic [20:0]        pnum_line_r [ptc_pkg::PNUM_TAPS];
  logic signed [33:0] m1_r, m1_nxt, dsq_r, dsq_nxt;
  logic signed [22:0] v1t_r, v1t_nxt;
  logic signed [36:0] m3_r, m3_nxt;
  logic signed [23:0] t_fine_r, t_fine_nxt;
  logic signed [26:0] tf5;
  logic signed [18:0] tq, tsat;
  logic signed [14:0] temp_nxt;
  logic signed [14:0] temp_line_r [ptc_pkg::TEMP_TAPS];
  logic signed [24:0] pv1_r, pv1_nxt;
  logic signed [49:0] sq_full;
  logic [46:0]        sq_r, sq_nxt;
  logic signed [40:0] pm5_r, pm5_nxt, pm2_r, pm2_nxt, pm5b_r, pm2b_r;
  logic signed [63:0] x6_r, x6_nxt, x3_r, x3_nxt;
  logic signed [63:0] v2_r, v2_nxt;
  logic signed [55:0] v1a_r, v1a_nxt;
  logic signed [56:0] a_r, a_nxt;
  logic signed [63:0] n_r, n_nxt, n10_r, n11_r;
  logic signed [56:0] hp_r, hp_nxt, dsum;
  logic [32:0]        lp_r, lp_nxt;
  logic signed [40:0] d_r, d_nxt;
  logic [UD_W-1:0]    ud12_r, ud12_nxt, ud13_r, ud14_r;
  logic [63:0]        un_r, un_nxt;
  logic               err12_r, err13_r, err14_r, neg12_r, neg13_r, neg14_r;
  logic [NUM_W-1:0]   pa_r, pa_nxt, pb_r, pb_nxt, nq_r, nq_nxt;

  always_comb begin
    t1d_nxt    = $signed({1'b0, in_raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
    dt_nxt     = $signed({1'b0, in_raw_temperature[19:4]}) - $signed({1'b0, t1});
    pnum_nxt   = 21'd1048576 - {1'b0, in_raw_pressure};
    m1_nxt     = t1d_r * t2;
    dsq_nxt    = dt_r * dt_r;
    v1t_nxt    = $signed(m1_r[33:11]);
    m3_nxt     = $signed({1'b0, dsq_r[31:12]}) * t3;
    t_fine_nxt = 24'(v1t_r) + 24'($signed(m3_r[36:14]));

    tf5 = 27'(t_fine_r) * 27'sd5 + 27'sd128;
    tq  = $signed(tf5[26:8]);
    priority if (tq < ptc_pkg::TEMP_MIN) tsat = 19'(ptc_pkg::TEMP_MIN);
    else if (tq > ptc_pkg::TEMP_MAX)     tsat = 19'(ptc_pkg::TEMP_MAX);
    else                                 tsat = tq;
    temp_nxt = 15'(tsat);
    pv1_nxt  = 25'(t_fine_r) - 25'sd128000;

    sq_full = pv1_r * pv1_r;
    sq_nxt  = sq_full[46:0];
    pm5_nxt = pv1_r * p5;
    pm2_nxt = pv1_r * p2;
    x6_nxt  = $signed({1'b0, sq_r}) * p6;
    x3_nxt  = $signed({1'b0, sq_r}) * p3;
    v2_nxt  = x6_r + (64'(pm5b_r) <<< 17) + (64'(p4) <<< 35);
    v1a_nxt = 56'(x3_r >>> 8) + (56'(pm2b_r) <<< 12);

    // offset by 2^47; the P1 product is split at bit 17
    a_nxt  = 57'(v1a_r) + (57'sd1 <<< 47);
    n_nxt  = (64'($signed({1'b0, pnum_line_r[ptc_pkg::PNUM_TAPS-1]})) <<< 31) - v2_r;
    hp_nxt = $signed(a_r[56:17]) * $signed({1'b0, p1});
    lp_nxt = a_r[16:0] * p1;
    dsum   = hp_r + 57'($signed({1'b0, lp_r[32:17]}));
    d_nxt  = $signed(dsum[56:16]);

    ud12_nxt = d_r[40] ? UD_W'(-d_r) : UD_W'(d_r);
    un_nxt   = n11_r[63] ? 64'(-n11_r) : 64'(n11_r);

    // |n| * 3125 as shifted terms
    pa_nxt = (NUM_W'(un_r) << 11) + (NUM_W'(un_r) << 10) + (NUM_W'(un_r) << 5);
    pb_nxt = (NUM_W'(un_r) << 4) + (NUM_W'(un_r) << 2) + NUM_W'(un_r);
    nq_nxt = pa_r + pb_r;
  end

  // divider pipeline arrays; index 0 is loaded by stage 15
  logic [UD_W-1:0] drem_r [QW+1];
  logic [QW-1:0]   dlo_r  [QW+1];
  logic [UD_W-1:0] dud_r  [QW+1];
  logic            dovf_r [QW+1];
  logic            dneg_r [QW+1];
  logic            derr_r [QW+1];

  always_ff @(posedge clk) begin
    t1d_r <= t1d_nxt;
    dt_r  <= dt_nxt;
    pnum_line_r[0] <= pnum_nxt;
    for (int k = 1; k < ptc_pkg::PNUM_TAPS; k++) pnum_line_r[k] <= pnum_line_r[k-1];
    m1_r     <= m1_nxt;
    dsq_r    <= dsq_nxt;
    v1t_r    <= v1t_nxt;
    m3_r     <= m3_nxt;
    t_fine_r <= t_fine_nxt;
    temp_line_r[0] <= temp_nxt;
    for (int k = 1; k < ptc_pkg::TEMP_TAPS; k++) temp_line_r[k] <= temp_line_r[k-1];
    pv1_r  <= pv1_nxt;
    sq_r   <= sq_nxt;
    pm5_r  <= pm5_nxt;
    pm2_r  <= pm2_nxt;
    x6_r   <= x6_nxt;
    x3_r   <= x3_nxt;
    pm5b_r <= pm5_r;
    pm2b_r <= pm2_r;
    v2_r   <= v2_nxt;
    v1a_r  <= v1a_nxt;
    a_r    <= a_nxt;
    n_r    <= n_nxt;
    hp_r   <= hp_nxt;
    lp_r   <= lp_nxt;
    n10_r  <= n_r;
    d_r    <= d_nxt;
    n11_r  <= n10_r;
    ud12_r  <= ud12_nxt;
    un_r    <= un_nxt;
    err12_r <= (d_r == '0);
    neg12_r <= n11_r[63] ^ d_r[40];
    pa_r    <= pa_nxt;
    pb_r    <= pb_nxt;
    ud13_r  <= ud12_r;
    err13_r <= err12_r;
    neg13_r <= neg12_r;
    nq_r    <= nq_nxt;
    ud14_r  <= ud13_r;
    err14_r <= err13_r;
    neg14_r <= neg13_r;
    // quotient of 2^QW or more saturates
    dovf_r[0] <= {1'b0, nq_r[NUM_W-1:QW]} >= ud14_r;
    drem_r[0] <= {1'b0, nq_r[NUM_W-1:QW]};
    dlo_r[0]  <= nq_r[QW-1:0];
    dud_r[0]  <= ud14_r;
    dneg_r[0] <= neg14_r;
    derr_r[0] <= err14_r;
  end

  // --------------------------------------------------------------------------
  // restoring divider, one quotient bit per stage
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < QW; i++) begin : g_div
    logic [UD_W+1:0] diff;
    logic [UD_W-1:0] rem_nxt;

    always_comb begin
      diff    = {1'b0, drem_r[i], dlo_r[i][QW-1]} - {2'b00, dud_r[i]};
      rem_nxt = diff[UD_W+1] ? {drem_r[i][UD_W-2:0], dlo_r[i][QW-1]} : diff[UD_W-1:0];
    end

    always_ff @(posedge clk) begin
      drem_r[i+1] <= rem_nxt;
      dlo_r[i+1]  <= {dlo_r[i][QW-2:0], ~diff[UD_W+1]};
      dud_r[i+1]  <= dud_r[i];
      dovf_r[i+1] <= dovf_r[i];
      dneg_r[i+1] <= dneg_r[i];
      derr_r[i+1] <= derr_r[i];
    end
  end

  // --------------------------------------------------------------------------
  // back stages: sign, second-order terms, saturation
  // --------------------------------------------------------------------------
  logic [QW-1:0]      qs;
  logic signed [37:0] pf1_r, pf1_nxt, pf2_r, pf3_r;
  logic signed [24:0] ap;
  logic signed [49:0] aa_full;
  logic [46:0]        aa_r, aa_nxt;
  logic signed [53:0] pp8_r, pp8_nxt, pp8b_r;
  logic signed [63:0] t9_r, t9_nxt;
  logic signed [39:0] sum_r, sum_nxt;
  logic signed [33:0] res;
  logic [24:0]        press_nxt, press_r;
  logic               errf1_r, errf2_r, errf3_r, errf4_r, err_out_r;

  always_comb begin
    if (dovf_r[QW] || (dlo_r[QW] > ptc_pkg::QUOT_LIMIT)) qs = ptc_pkg::QUOT_LIMIT;
    else                                                  qs = dlo_r[QW];
    pf1_nxt = dneg_r[QW] ? -$signed({1'b0, qs}) : $signed({1'b0, qs});
    ap      = $signed(pf1_r[37:13]);
    aa_full = ap * ap;
    aa_nxt  = aa_full[46:0];
    pp8_nxt = pf1_r * p8;
    t9_nxt  = $signed({1'b0, aa_r}) * p9;
    sum_nxt = 40'(pf3_r) + 40'(t9_r >>> 25) + 40'(pp8b_r >>> 19);
    res     = 34'($signed(sum_r[39:8])) + (34'(p7) <<< 4);
    priority if (errf4_r)                press_nxt = '0;
    else if (res < 0)                    press_nxt = '0;
    else if (res > ptc_pkg::PRESS_MAX)   press_nxt = 25'(ptc_pkg::PRESS_MAX);
    else                                 press_nxt = 25'(res);
  end

  always_ff @(posedge clk) begin
    pf1_r     <= pf1_nxt;
    errf1_r   <= derr_r[QW];
    aa_r      <= aa_nxt;
    pp8_r     <= pp8_nxt;
    pf2_r     <= pf1_r;
    errf2_r   <= errf1_r;
    t9_r      <= t9_nxt;
    pp8b_r    <= pp8_r;
    pf3_r     <= pf2_r;
    errf3_r   <= errf2_r;
    sum_r     <= sum_nxt;
    errf4_r   <= errf3_r;
    press_r   <= press_nxt;
    err_out_r <= errf4_r;
  end

  assign out_valid             = vld_r[LAT-1];
  assign out_temperature_centi = temp_line_r[ptc_pkg::TEMP_TAPS-1];
  assign out_pressure_q8       = press_r;
  assign out_divide_error      = err_out_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  logic item_acc, err_strobe, press_zero, temp_ok;

  assign item_acc   = start && !busy;
  assign err_strobe = out_valid && out_divide_error;
  assign press_zero = (out_pressure_q8 == '0);
  assign temp_ok    = (out_temperature_centi >= ptc_pkg::TEMP_MIN) &&
                      (out_temperature_centi <= ptc_pkg::TEMP_MAX);

  `PTC_ASSERT_NOW(a_err_zero, err_strobe, press_zero, "pressure set on divide error")
  `PTC_ASSERT_NOW(a_temp_range, out_valid, temp_ok, "temperature out of range")
  `PTC_ASSERT_NOW(a_latency, item_acc, ##(LAT) out_valid, "item lost in pipeline")
  `PTC_ASSERT_NEXT(a_no_phantom, !item_acc, ##(LAT - 1) !out_valid, "result without item")

endmodule

`default_nettype wire
